### rtl/xpd_pkg.sv
// shared types and constants of the x86 prefix decoder
// no dependencies; imported by every rtl module of the block
package xpd_pkg;

   // prefix byte codes
   localparam logic [7:0] BYTE_OPSIZE   = 8'h66;
   localparam logic [7:0] BYTE_ADDRSIZE = 8'h67;
   localparam logic [7:0] BYTE_SEG_CS   = 8'h2E;
   localparam logic [7:0] BYTE_SEG_ES   = 8'h26;
   localparam logic [7:0] BYTE_SEG_SS   = 8'h36;
   localparam logic [7:0] BYTE_SEG_DS   = 8'h3E;
   localparam logic [7:0] BYTE_LOCK     = 8'hF0;
   localparam logic [7:0] BYTE_SEG_FS   = 8'h64;
   localparam logic [7:0] BYTE_SEG_GS   = 8'h65;

   // data segment codes
   localparam logic [1:0] SEG_DS = 2'd0;
   localparam logic [1:0] SEG_CS = 2'd1;
   localparam logic [1:0] SEG_ES = 2'd2;
   localparam logic [1:0] SEG_SS = 2'd3;

   // result status codes
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_UNSUPPORTED = 1'b1;

   localparam logic [3:0] COUNT_MAX = 4'd15;

   // packed widths of the stream payloads
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;

   // what one code byte means
   typedef enum logic [2:0] {
      KIND_OPSIZE,
      KIND_ADDRSIZE,
      KIND_SEGMENT,
      KIND_UNSUPPORTED,
      KIND_OPCODE
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [1:0] segment;
   } class_type;

   // one result item
   typedef struct packed {
      logic [7:0] opcode;
      logic       operand_size_override;
      logic       address_size_override;
      logic [1:0] data_segment;
      logic       segment_overridden;
      logic [3:0] prefix_count;
      logic       status;
   } result_type;

endpackage

### rtl/xpd_classify.sv
// byte classifier: sorts one code byte into prefix kinds or opcode
// depends on xpd_pkg
module xpd_classify (
   input  logic [7:0]         code_byte,
   output xpd_pkg::class_type cls
);
   import xpd_pkg::*;

   // decode the byte against the prefix table
   always_comb begin
      cls.segment = SEG_DS;
      case (code_byte)
         BYTE_OPSIZE:   cls.kind = KIND_OPSIZE;
         BYTE_ADDRSIZE: cls.kind = KIND_ADDRSIZE;
         BYTE_SEG_CS: begin
            cls.kind    = KIND_SEGMENT;
            cls.segment = SEG_CS;
         end
         BYTE_SEG_ES: begin
            cls.kind    = KIND_SEGMENT;
            cls.segment = SEG_ES;
         end
         BYTE_SEG_SS: begin
            cls.kind    = KIND_SEGMENT;
            cls.segment = SEG_SS;
         end
         BYTE_SEG_DS: begin
            cls.kind    = KIND_SEGMENT;
            cls.segment = SEG_DS;
         end
         BYTE_LOCK, BYTE_SEG_FS, BYTE_SEG_GS: cls.kind = KIND_UNSUPPORTED;
         default:       cls.kind = KIND_OPCODE;
      endcase
   end

endmodule

### rtl/xpd_collect.sv
// prefix state: gathers flags and count, forms the result of a closing byte
// depends on xpd_pkg
module xpd_collect (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [7:0]          code_byte,
   input  xpd_pkg::class_type  cls,
   output xpd_pkg::result_type result,
   output logic                closes
);
   import xpd_pkg::*;

   logic       opsize_ff,   opsize_in;
   logic       addrsize_ff, addrsize_in;
   logic [1:0] segment_ff,  segment_in;
   logic       override_ff, override_in;
   logic [3:0] count_ff,    count_in;
   logic [3:0] count_bump;

   // an opcode or an unsupported prefix ends the run
   assign closes = (cls.kind == KIND_OPCODE) || (cls.kind == KIND_UNSUPPORTED);

   // result from the state gathered before this byte
   always_comb begin
      result.opcode                = (cls.kind == KIND_OPCODE) ? code_byte : 8'd0;
      result.operand_size_override = opsize_ff;
      result.address_size_override = addrsize_ff;
      result.data_segment          = segment_ff;
      result.segment_overridden    = override_ff;
      result.prefix_count          = count_ff;
      result.status                = (cls.kind == KIND_UNSUPPORTED) ?
                                     STATUS_UNSUPPORTED : STATUS_OK;
   end

   // saturating prefix count
   assign count_bump = (count_ff == COUNT_MAX) ? count_ff : count_ff + 4'd1;

   // next state
   always_comb begin
      opsize_in   = opsize_ff;
      addrsize_in = addrsize_ff;
      segment_in  = segment_ff;
      override_in = override_ff;
      count_in    = count_ff;
      if (advance) begin
         case (cls.kind)
            KIND_OPSIZE: begin
               opsize_in = 1'b1;
               count_in  = count_bump;
            end
            KIND_ADDRSIZE: begin
               addrsize_in = 1'b1;
               count_in    = count_bump;
            end
            KIND_SEGMENT: begin
               segment_in  = cls.segment;
               override_in = 1'b1;
               count_in    = count_bump;
            end
            default: begin
               opsize_in   = 1'b0;
               addrsize_in = 1'b0;
               segment_in  = SEG_DS;
               override_in = 1'b0;
               count_in    = 4'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opsize_ff   <= 1'b0;
         addrsize_ff <= 1'b0;
         segment_ff  <= SEG_DS;
         override_ff <= 1'b0;
         count_ff    <= 4'd0;
      end else begin
         opsize_ff   <= opsize_in;
         addrsize_ff <= addrsize_in;
         segment_ff  <= segment_in;
         override_ff <= override_in;
         count_ff    <= count_in;
      end
   end

endmodule

### rtl/x86_prefix_decoder.sv
// x86 prefix decoder: takes one code byte per request and collects the
// operand-size, address-size and segment prefixes ahead of an opcode. A byte
// is latched into an input register, classified from there and folded into
// the prefix state, and a closing byte (an opcode, or an unsupported
// 0xF0/0x64/0x65 which returns status 1 and opcode zero) loads the result
// register. One byte per cycle is sustained unless a closing byte meets a
// full, stalled result register; a result passes through the input register
// and then the result register, and prefix bytes give no result. The input
// register and result register together hold two bytes when the result side
// stalls.
// depends on xpd_pkg, xpd_classify, xpd_collect
module x86_prefix_decoder (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [xpd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [7:0] code_byte
   // result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] opcode, [8] operand_size_override, [9] address_size_override,
   // [11:10] data_segment, [12] segment_overridden, [16:13] prefix_count
   output logic [xpd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tuser   // [0] status
);
   import xpd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_rec_ff;
   class_type  cls;
   result_type result;
   logic       closes;
   logic       advance;
   logic       req_take;

   xpd_classify u_classify (
      .code_byte (in_byte_ff),
      .cls       (cls)
   );

   xpd_collect u_collect (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .code_byte (in_byte_ff),
      .cls       (cls),
      .result    (result),
      .closes    (closes)
   );

   // a held byte moves on unless it closes a run into a full, stalled slot
   assign advance    = in_valid_ff && (!closes || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = (advance && closes) || (out_valid_ff && !rsp_tready);

   // input register and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_tdata[7:0];
      end
      if (advance && closes) begin
         out_rec_ff <= result;
      end
   end

   // result packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_rec_ff.status;
   assign rsp_tdata  = {7'd0,
                        out_rec_ff.prefix_count,
                        out_rec_ff.segment_overridden,
                        out_rec_ff.data_segment,
                        out_rec_ff.address_size_override,
                        out_rec_ff.operand_size_override,
                        out_rec_ff.opcode};

`ifndef NO_ASSERTIONS
   // a closing byte that moves on always shows up as a result next cycle
   a_close_loads: assert property (@(posedge clock) disable iff (reset)
      advance && closes |=> rsp_tvalid)
      else $error("closing byte did not produce a result");

   // an unsupported prefix never carries an opcode
   a_error_opcode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == STATUS_UNSUPPORTED) |-> (rsp_tdata[7:0] == 8'd0))
      else $error("error result with nonzero opcode");

   // a closing byte that directly follows another one carries a zero prefix count
   a_clean_after: assert property (@(posedge clock) disable iff (reset)
      advance && closes |=> !(advance && closes) || (result.prefix_count == 4'd0))
      else $error("prefix state not cleared after a result");

   // an empty input register never backpressures the request side
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("request stalled with empty input register");
`endif

endmodule
